// ----- design/ast_pkg.sv -----
package ast_pkg;

  localparam int unsigned CfgDataW = 34;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned SqW      = 32;

  localparam logic [33:0]        QuietLevelSqRst = 34'd167772;
  localparam logic [33:0]        ShakeLevelSqRst = 34'd2055209;
  localparam logic [3:0]         ConfirmHitsRst  = 4'd2;
  localparam logic [15:0]        CooldownMsRst   = 16'd900;
  localparam logic signed [15:0] PrevXRst        = 16'sd0;
  localparam logic signed [15:0] PrevYRst        = 16'sd0;
  localparam logic signed [15:0] PrevZRst        = 16'sd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUIET_LEVEL_SQ = 2'd0,
    CFG_SHAKE_LEVEL_SQ = 2'd1,
    CFG_CONFIRM_HITS   = 2'd2,
    CFG_COOLDOWN_MS    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               read_ok;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;
  } in_t;

  typedef struct packed {
    logic        shake_seen;
    logic        roll_trigger;
    logic        armed_now;
    logic [33:0] change_sq;
  } out_t;

  typedef struct packed {
    logic [33:0] quiet_level_sq;
    logic [33:0] shake_level_sq;
    logic [3:0]  confirm_hits;
    logic [15:0] cooldown_ms;
  } cfg_t;

  // control and side data of the squaring stage
  typedef struct packed {
    logic        valid;
    logic        read_ok;
    logic [31:0] time_ms;
  } stage_t;

endpackage

// ----- design/ast_lane.sv -----
module ast_lane
  import ast_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] cur_i,
  input  logic signed [15:0] prev_i,
  output logic [SqW-1:0]     sq_o
);

  logic signed [16:0] diff;
  logic [15:0]        mag;
  logic [SqW-1:0]     sq_d, sq_q;

  always_comb begin
    diff = 17'(cur_i) - 17'(prev_i);
    mag  = diff[16] ? 16'(-diff) : diff[15:0];
    sq_d = SqW'(mag) * SqW'(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

// ----- design/ast_merge.sv -----
module ast_merge
  import ast_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfg_t           cfg_i,
  input  stage_t         stage_i,
  input  logic           en_i,
  input  logic [SqW-1:0] sq_x_i,
  input  logic [SqW-1:0] sq_y_i,
  input  logic [SqW-1:0] sq_z_i,
  output logic           out_valid_o,
  output out_t           out_data_o
);

  logic        armed_q, armed_d;
  logic [3:0]  hit_q, hit_d;
  logic [31:0] last_roll_q, last_roll_d;
  logic        rolled_q, rolled_d;
  logic        out_valid_q;
  out_t        out_q, out_d;
  logic [33:0] change;
  logic [3:0]  hit_inc;
  logic [31:0] dt;
  logic        shake, roll;

  always_comb begin
    armed_d     = armed_q;
    hit_d       = hit_q;
    last_roll_d = last_roll_q;
    rolled_d    = rolled_q;
    shake       = 1'b0;
    roll        = 1'b0;
    change      = 34'd0;
    hit_inc     = hit_q;
    dt          = stage_i.time_ms - last_roll_q;

    if (!stage_i.read_ok) begin
      hit_d = 4'd0;
    end else begin
      change = 34'(sq_x_i) + 34'(sq_y_i) + 34'(sq_z_i);
      // quiet test wins over the shake test
      priority if (change < cfg_i.quiet_level_sq) begin
        armed_d = 1'b1;
        hit_d   = 4'd0;
      end else if (armed_q && change >= cfg_i.shake_level_sq) begin
        if (hit_q < cfg_i.confirm_hits) begin
          hit_inc = hit_q + 4'd1;
        end
        hit_d = hit_inc;
        if (hit_inc >= cfg_i.confirm_hits) begin
          armed_d = 1'b0;
          hit_d   = 4'd0;
          shake   = 1'b1;
        end
      end else begin
        // between the levels or disarmed: state holds
      end
    end

    if (shake && (!rolled_q || dt >= 32'(cfg_i.cooldown_ms))) begin
      roll        = 1'b1;
      last_roll_d = stage_i.time_ms;
      rolled_d    = 1'b1;
    end

    out_d.shake_seen   = shake;
    out_d.roll_trigger = roll;
    out_d.armed_now    = armed_d;
    out_d.change_sq    = change;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b1;
      hit_q       <= 4'd0;
      last_roll_q <= 32'd0;
      rolled_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= stage_i.valid;
      if (stage_i.valid) begin
        armed_q     <= armed_d;
        hit_q       <= hit_d;
        last_roll_q <= last_roll_d;
        rolled_q    <= rolled_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/accel_shake_trigger.sv -----
// channel | dir | handshake             | payload
// in      | in  | in_valid_i/in_stall_o | in_data_i  (in_t)
// out     | out | out_valid_o/out_stall_i| out_data_o (out_t)
// cfg     | in  | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// one sample per cycle sustained while the output is not stalled; a result
// passes first through the three squaring lanes, then the merge stage.
// reset restores the register defaults and the detector state (armed,
// previous sample at one g on z); no clearing pass.
// a stalled output holds its result; the squaring stage keeps filling, so
// the input stalls only when both stages are occupied.
module accel_shake_trigger
  import ast_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t               cfg_q;
  logic signed [15:0] prev_x_q, prev_y_q, prev_z_q;
  stage_t             stage_q;
  logic               en_out, en_s1, in_xfer;
  logic [SqW-1:0]     sq_x, sq_y, sq_z;

  assign en_out     = !out_valid_o || !out_stall_i;
  assign en_s1      = !stage_q.valid || en_out;
  assign in_stall_o = !en_s1;
  assign in_xfer    = in_valid_i && en_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quiet_level_sq <= QuietLevelSqRst;
      cfg_q.shake_level_sq <= ShakeLevelSqRst;
      cfg_q.confirm_hits   <= ConfirmHitsRst;
      cfg_q.cooldown_ms    <= CooldownMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_QUIET_LEVEL_SQ: cfg_q.quiet_level_sq <= cfg_data_i[33:0];
        CFG_SHAKE_LEVEL_SQ: cfg_q.shake_level_sq <= cfg_data_i[33:0];
        CFG_CONFIRM_HITS:   cfg_q.confirm_hits   <= cfg_data_i[3:0];
        CFG_COOLDOWN_MS:    cfg_q.cooldown_ms    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // previous sample depends only on the input, so it advances at a read_ok transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= PrevXRst;
      prev_y_q <= PrevYRst;
      prev_z_q <= PrevZRst;
    end else if (in_xfer && in_data_i.read_ok) begin
      prev_x_q <= in_data_i.accel_x;
      prev_y_q <= in_data_i.accel_y;
      prev_z_q <= in_data_i.accel_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_s1) begin
      stage_q.valid   <= in_valid_i;
      stage_q.read_ok <= in_data_i.read_ok;
      stage_q.time_ms <= in_data_i.time_ms;
    end
  end

  ast_lane u_lane_x (
    .clk_i  (clk_i),
    .en_i   (en_s1),
    .cur_i  (in_data_i.accel_x),
    .prev_i (prev_x_q),
    .sq_o   (sq_x)
  );

  ast_lane u_lane_y (
    .clk_i  (clk_i),
    .en_i   (en_s1),
    .cur_i  (in_data_i.accel_y),
    .prev_i (prev_y_q),
    .sq_o   (sq_y)
  );

  ast_lane u_lane_z (
    .clk_i  (clk_i),
    .en_i   (en_s1),
    .cur_i  (in_data_i.accel_z),
    .prev_i (prev_z_q),
    .sq_o   (sq_z)
  );

  ast_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .stage_i     (stage_q),
    .en_i        (en_out),
    .sq_x_i      (sq_x),
    .sq_y_i      (sq_y),
    .sq_z_i      (sq_z),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- design/ast_checker.sv -----
module ast_checker
  import ast_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_roll_needs_shake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.roll_trigger |-> out_data_o.shake_seen)
    else $error("roll trigger without shake");

  a_shake_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.shake_seen |-> !out_data_o.armed_now)
    else $error("shake reported while still armed");

  // an output slot is free, so the input must be taking transfers
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind accel_shake_trigger ast_checker u_ast_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
